### design/fct_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fct_pkg: shared types and constants of the frustum cull test
// Query word layout, per-plane reject flags and the op codes.
// ---------------------------------------------------------------------------
package fct_pkg;

  // Number of plane registers on the configuration port.
  localparam int PLANE_REGS = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Query kinds.
  localparam logic [1:0] OP_POINT  = 2'd0;
  localparam logic [1:0] OP_SPHERE = 2'd1;
  localparam logic [1:0] OP_BOX    = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // One accepted query word. Axes are packed z,y,x, each signed Q1.14.
  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic signed [15:0] center_z;
    logic signed [15:0] radius;
    logic [2:0][47:0]   axis;
    logic [2:0][15:0]   extent;
  } query_t;

  // Outcome of one plane for each query kind.
  typedef struct packed {
    logic point;
    logic sphere;
    logic box;
  } rej_t;

endpackage

### design/fct_plane_lane.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fct_plane_lane: four-stage test of one query against one plane
// Produces the reject flags for point, sphere and box for each query word.
// ---------------------------------------------------------------------------
module fct_plane_lane
  import fct_pkg::*;
(
  input  logic                  clk_i,
  input  logic [CFG_DATA_W-1:0] plane_i,
  input  query_t                query_i,
  output rej_t                  rej_o
);

  logic signed [15:0] n_x, n_y, n_z, plane_dist;
  assign n_x        = plane_i[15:0];
  assign n_y        = plane_i[31:16];
  assign n_z        = plane_i[47:32];
  assign plane_dist = plane_i[63:48];

  // Stage 1: all 16x16 products.
  logic signed [31:0] nc_d [3];
  logic signed [31:0] nc_q [3];
  logic signed [31:0] na_d [3][3];
  logic signed [31:0] na_q [3][3];
  logic signed [15:0] dist1_q, r1_q;
  logic signed [15:0] ex1_q [3];

  always_comb begin
    logic signed [15:0] ax_x, ax_y, ax_z;
    nc_d[0] = n_x * query_i.center_x;
    nc_d[1] = n_y * query_i.center_y;
    nc_d[2] = n_z * query_i.center_z;
    for (int k = 0; k < 3; k++) begin
      ax_x = query_i.axis[k][15:0];
      ax_y = query_i.axis[k][31:16];
      ax_z = query_i.axis[k][47:32];
      na_d[k][0] = n_x * ax_x;
      na_d[k][1] = n_y * ax_y;
      na_d[k][2] = n_z * ax_z;
    end
  end

  always_ff @(posedge clk_i) begin
    nc_q    <= nc_d;
    na_q    <= na_d;
    dist1_q <= plane_dist;
    r1_q    <= query_i.radius;
    for (int k = 0; k < 3; k++) begin
      ex1_q[k] <= query_i.extent[k];
    end
  end

  // Stage 2: signed distance of the center and the three axis projections.
  logic signed [33:0] s_d, s2_q;
  logic signed [33:0] dot_d [3];
  logic signed [33:0] dot_q [3];
  logic signed [15:0] r2_q;
  logic signed [15:0] ex2_q [3];

  always_comb begin
    s_d = 34'(nc_q[0]) + 34'(nc_q[1]) + 34'(nc_q[2]) + (34'(dist1_q) <<< 14);
    for (int k = 0; k < 3; k++) begin
      dot_d[k] = 34'(na_q[k][0]) + 34'(na_q[k][1]) + 34'(na_q[k][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    s2_q  <= s_d;
    dot_q <= dot_d;
    r2_q  <= r1_q;
    ex2_q <= ex1_q;
  end

  // Stage 3: scale projections by the extents; point and sphere decided here.
  logic signed [49:0] m_d [3];
  logic signed [49:0] m_q [3];
  logic signed [34:0] sph_diff;
  logic signed [33:0] s3_q;
  logic               pt3_q, sph3_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m_d[k] = ex2_q[k] * dot_q[k];
    end
    sph_diff = 35'(s2_q) - (35'(r2_q) <<< 14);
  end

  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    s3_q   <= s2_q;
    pt3_q  <= (s2_q > 34'sd0);
    sph3_q <= (sph_diff > 35'sd0);
  end

  // Stage 4: half-span of the box along the plane normal.
  logic [49:0] mag [3];
  logic [51:0] span_d, span_q;
  logic signed [33:0] s4_q;
  logic               pt4_q, sph4_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k] = m_q[k][49] ? 50'(-m_q[k]) : 50'(m_q[k]);
    end
    span_d = 52'(mag[0]) + 52'(mag[1]) + 52'(mag[2]);
  end

  always_ff @(posedge clk_i) begin
    span_q <= span_d;
    s4_q   <= s3_q;
    pt4_q  <= pt3_q;
    sph4_q <= sph3_q;
  end

  // Box compare in units of 2^-32.
  logic signed [52:0] lhs, rhs;
  assign lhs = 53'(s4_q) <<< 14;
  assign rhs = $signed({1'b0, span_q});

  assign rej_o.point  = pt4_q;
  assign rej_o.sphere = sph4_q;
  assign rej_o.box    = (lhs > rhs);

endmodule

### design/frustum_cull_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frustum_cull_test: point, sphere and oriented box test against the frustum
// Tests one query word per cycle against up to six outward-facing planes
// held in configuration registers and returns one inside flag per query.
// ---------------------------------------------------------------------------
//
// Channel     Direction  Handshake             Payload
// ---------   ---------  --------------------  ------------------------------
// query       in         start_i && !busy_o    op_i, center_*_i, radius_i,
//                                              axis_*_i, extent_*_i
// result      out        done_o (one cycle)    inside_res_o
// config      in         cfg_we_i              cfg_idx_i, cfg_wdata_i
//
// A query word accepted at one clock edge shows its result, with done_o high,
// after one input register, four lane stages and the output register, one
// word per cycle sustained. busy_o is always low, since every stage advances
// each cycle and the receiver cannot stall.
// Reset clears the plane registers to zero and empties the valid pipeline;
// data registers are not reset.
// ---------------------------------------------------------------------------
module frustum_cull_test
  import fct_pkg::*;
#(
  parameter int PLANE_COUNT = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // query
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [1:0]            op_i,
  input  logic signed [15:0]    center_x_i,
  input  logic signed [15:0]    center_y_i,
  input  logic signed [15:0]    center_z_i,
  input  logic signed [15:0]    radius_i,
  input  logic [47:0]           axis_a_i,
  input  logic [47:0]           axis_b_i,
  input  logic [47:0]           axis_c_i,
  input  logic signed [15:0]    extent_a_i,
  input  logic signed [15:0]    extent_b_i,
  input  logic signed [15:0]    extent_c_i,
  // result
  output logic                  done_o,
  output logic                  inside_res_o,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // Planes past the register file would hold zero and so reject only spheres of
  // negative radius; only the registered planes get a lane.
  localparam int LANES = (PLANE_COUNT < PLANE_REGS) ? PLANE_COUNT : PLANE_REGS;
  // Query register plus the four lane stages.
  localparam int DEPTH = 5;

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Plane registers. Writes to indices past the last plane are dropped.
  logic [CFG_DATA_W-1:0] planes_d [PLANE_REGS];
  logic [CFG_DATA_W-1:0] planes_q [PLANE_REGS];

  always_comb begin
    planes_d = planes_q;
    for (int i = 0; i < PLANE_REGS; i++) begin
      if (cfg_we_i && (cfg_idx_i == CFG_IDX_W'(i))) begin
        planes_d[i] = cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PLANE_REGS; i++) begin
        planes_q[i] <= '0;
      end
    end else begin
      planes_q <= planes_d;
    end
  end

  // Input register: the query word is held here for the lanes.
  query_t query_d, query_q;

  always_comb begin
    query_d          = query_q;
    if (accept) begin
      query_d.op       = op_i;
      query_d.center_x = center_x_i;
      query_d.center_y = center_y_i;
      query_d.center_z = center_z_i;
      query_d.radius   = radius_i;
      query_d.axis     = {axis_c_i, axis_b_i, axis_a_i};
      query_d.extent   = {extent_c_i, extent_b_i, extent_a_i};
    end
  end

  always_ff @(posedge clk_i) begin
    query_q <= query_d;
  end

  // Valid bits and op codes travel alongside the lane stages.
  logic [DEPTH-1:0]       vld_d, vld_q;
  logic [DEPTH-1:0][1:0]  op_d, op_q;

  assign vld_d = {vld_q[DEPTH-2:0], accept};
  assign op_d  = {op_q[DEPTH-2:0], op_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
  end

  // One lane per plane, all in lockstep.
  rej_t rej [LANES];

  for (genvar g = 0; g < LANES; g++) begin : gen_lane
    fct_plane_lane u_lane (
      .clk_i   (clk_i),
      .plane_i (planes_q[g]),
      .query_i (query_q),
      .rej_o   (rej[g])
    );
  end

  // Any plane rejecting the query culls it; an unused op code is never
  // tested and so always reads as inside.
  logic any_pt, any_sph, any_box, culled;

  always_comb begin
    any_pt  = 1'b0;
    any_sph = 1'b0;
    any_box = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      any_pt  = any_pt  | rej[i].point;
      any_sph = any_sph | rej[i].sphere;
      any_box = any_box | rej[i].box;
    end
    case (op_q[DEPTH-1])
      OP_POINT:  culled = any_pt;
      OP_SPHERE: culled = any_sph;
      OP_BOX:    culled = any_box;
      default:   culled = 1'b0;
    endcase
  end

  // Output register: the result word is shown for exactly one cycle.
  logic done_d, done_q;
  logic inside_d, inside_q;

  assign done_d   = vld_q[DEPTH-1];
  assign inside_d = !culled;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inside_q <= inside_d;
  end

  assign done_o       = done_q;
  assign inside_res_o = inside_q;

endmodule

### design/fct_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fct_checker: port-level checks of the frustum cull test
// Checks the fixed result latency, the untested op code and that busy_o never rises.
// ---------------------------------------------------------------------------
module fct_checker
  import fct_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic [1:0] op_i,
  input logic       done_o,
  input logic       inside_res_o
);

  localparam int LAT = 6;

  // Every accepted word yields a result strobe after the fixed latency.
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("result strobe missing after accepted word");

  // No strobe appears without an accepted word behind it.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |-> ##LAT !done_o)
    else $error("result strobe without accepted word");

  // The unused op code is never culled.
  a_none_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (op_i == OP_NONE)) |-> ##LAT inside_res_o)
    else $error("unused op code was culled");

  // The block never holds off a query.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised");

endmodule

bind frustum_cull_test fct_checker u_fct_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .op_i         (op_i),
  .done_o       (done_o),
  .inside_res_o (inside_res_o)
);

### dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for the frustum cull test
// Drives point, sphere and oriented box query words through the command
// port, programs the six plane registers between phases, predicts every
// inside flag in exact 64-bit integer arithmetic and checks each done strobe.
// ---------------------------------------------------------------------------
module tb;
  import fct_pkg::*;

  // The run ends well before this even with the longest idle bursts.
  localparam int CYCLE_LIMIT     = 200000;
  // Extra idle wait once nothing is outstanding.
  localparam int DRAIN_CYCLES    = 12;
  localparam int RANDOM_PHASES   = 8;
  localparam int WORDS_PER_PHASE = 244;
  // Half-size of the cube frustum used by the directed words (100.0 in Q11.4).
  localparam int CUBE_HALF       = 1600;

  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
  localparam logic [47:0] AXIS_X   = 48'h0000_0000_4000;
  localparam logic [47:0] AXIS_Y   = 48'h0000_4000_0000;
  localparam logic [47:0] AXIS_Z   = 48'h4000_0000_0000;
  localparam logic [47:0] LANE_MAX = 48'h7FFF_7FFF_7FFF;
  localparam logic [47:0] LANE_MIN = 48'h8000_8000_8000;

  // Ways of filling the plane registers for one phase.
  typedef enum int {
    STYLE_ZERO,
    STYLE_CUBE,
    STYLE_TILTED,
    STYLE_RANDOM,
    STYLE_EXTREME,
    STYLE_SPARSE
  } plane_style_e;

  // Holds a copy of the plane registers and the queue of predicted inside
  // flags, one per accepted query word, oldest first.
  class inside_checker;
    logic [63:0] plane_regs [PLANE_REGS];
    bit          inside_expected [$];
    int          accepted;
    int          checked;
    int          mismatches;
    int          inside_cnt;
    int          culled_cnt;

    function new();
      foreach (plane_regs[i]) plane_regs[i] = '0;
      accepted   = 0;
      checked    = 0;
      mismatches = 0;
      inside_cnt = 0;
      culled_cnt = 0;
    endfunction

    // Writes past the last plane register are dropped by the block.
    function void write_plane(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx < PLANE_REGS) plane_regs[idx] = value;
    endfunction

    function longint lane(logic [63:0] w, int k);
      return longint'($signed(w[16*k +: 16]));
    endfunction

    // Normal (Q1.14) dot axis (Q1.14), units of 2^-28.
    function longint normal_dot(logic [63:0] pl, logic [47:0] v);
      return lane(pl, 0) * lane(v, 0) + lane(pl, 1) * lane(v, 1) + lane(pl, 2) * lane(v, 2);
    endfunction

    function bit predict_inside(query_t q);
      longint cx, cy, cz, r, s, span, term;
      bit     rejected;
      if (q.op == OP_NONE) return 1'b1;
      cx = q.center_x;
      cy = q.center_y;
      cz = q.center_z;
      r  = q.radius;
      foreach (plane_regs[i]) begin
        // Signed distance of the center in units of 2^-18.
        s = lane(plane_regs[i], 0) * cx + lane(plane_regs[i], 1) * cy +
            lane(plane_regs[i], 2) * cz + lane(plane_regs[i], 3) * 16384;
        rejected = 1'b0;
        case (q.op)
          OP_POINT:  rejected = s > 0;
          OP_SPHERE: rejected = (s - r * 16384) > 0;
          OP_BOX: begin
            // Projected half-size of the box, units of 2^-32. Only the
            // magnitude of each term counts, so negative extents act as
            // positive ones.
            span = 0;
            for (int k = 0; k < 3; k++) begin
              term = longint'($signed(q.extent[k])) * normal_dot(plane_regs[i], q.axis[k]);
              span += (term < 0) ? -term : term;
            end
            rejected = s * 16384 > span;
          end
          default: rejected = 1'b0;
        endcase
        if (rejected) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_query(query_t q);
      bit want;
      want = predict_inside(q);
      inside_expected.push_back(want);
      accepted++;
      if (want) inside_cnt++;
      else culled_cnt++;
    endfunction

    function void check_result(logic got);
      bit want;
      if (inside_expected.size() == 0) begin
        $display("time %0t: result with no query pending, expected none, got %b", $time, got);
        mismatches++;
      end else begin
        want = inside_expected.pop_front();
        checked++;
        if (got !== want) begin
          $display("time %0t: inside_res mismatch, expected %b, got %b", $time, want, got);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return inside_expected.size();
    endfunction

    function void report_leftover();
      if (inside_expected.size() != 0) begin
        $display("time %0t: %0d results never arrived, expected %0d more, got none",
                 $time, inside_expected.size(), inside_expected.size());
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic                  done_o;
  logic                  inside_res_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  // The query word on the input ports; every payload port is a field of it.
  query_t                query_word;

  inside_checker board;
  int            cycle_cnt = 0;

  plane_style_e phase_style [RANDOM_PHASES] = '{STYLE_CUBE, STYLE_RANDOM, STYLE_TILTED,
                                                STYLE_EXTREME, STYLE_SPARSE, STYLE_CUBE,
                                                STYLE_TILTED, STYLE_CUBE};

  always #6 clk_i = ~clk_i;

  frustum_cull_test u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .op_i         (query_word.op),
    .center_x_i   (query_word.center_x),
    .center_y_i   (query_word.center_y),
    .center_z_i   (query_word.center_z),
    .radius_i     (query_word.radius),
    .axis_a_i     (query_word.axis[0]),
    .axis_b_i     (query_word.axis[1]),
    .axis_c_i     (query_word.axis[2]),
    .extent_a_i   (query_word.extent[0]),
    .extent_b_i   (query_word.extent[1]),
    .extent_c_i   (query_word.extent[2]),
    .done_o       (done_o),
    .inside_res_o (inside_res_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Everything the block sees or shows is sampled at the rising edge; inputs
  // only move at the falling edge, so the samples never race the drivers.
  // A result strobe is checked before a new word is noted, though either
  // order would give the same queue contents.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o !== 1'b0) board.check_result(inside_res_o);
      if (start_i && !busy_o) board.note_query(query_word);
      if (cfg_we_i) board.write_plane(cfg_idx_i, cfg_wdata_i);
    end
  end

  // Watchdog: a stuck handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_cnt, board.pending());
      $display("FAIL");
      $finish;
    end
  end

  // Signed value spread evenly over [-span, span], truncated to 16 bits.
  function automatic logic [15:0] rand_s16(int span);
    return 16'($urandom_range(0, 2 * span) - span);
  endfunction

  // Centers are mostly near the planes of interest, sometimes anywhere.
  function automatic logic [15:0] coord(int span);
    return ($urandom_range(0, 3) == 0) ? 16'($urandom) : rand_s16(span);
  endfunction

  // Radius and extents: mostly modest and positive, some negative, a few
  // covering the whole 16-bit range.
  function automatic logic [15:0] size_value(int span);
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'($urandom);
    if (pick == 1) return 16'(-$urandom_range(0, span / 4));
    return 16'($urandom_range(0, span / 4));
  endfunction

  function automatic query_t make_query(logic [1:0] op, int cx, int cy, int cz, int r,
                                        logic [47:0] a, logic [47:0] b, logic [47:0] c,
                                        int ea, int eb, int ec);
    query_t q;
    q.op        = op;
    q.center_x  = 16'(cx);
    q.center_y  = 16'(cy);
    q.center_z  = 16'(cz);
    q.radius    = 16'(r);
    q.axis[0]   = a;
    q.axis[1]   = b;
    q.axis[2]   = c;
    q.extent[0] = 16'(ea);
    q.extent[1] = 16'(eb);
    q.extent[2] = 16'(ec);
    return q;
  endfunction

  // Presents one word at this falling edge and holds it until the monitor
  // has seen it accepted. Returns at a falling edge with start_i still high,
  // so a following word goes out back to back.
  task automatic send_query(input query_t q);
    int target;
    target = board.accepted + 1;
    query_word <= q;
    start_i    <= 1'b1;
    do @(negedge clk_i); while (board.accepted < target);
  endtask

  task automatic pause_sender(input int cycles);
    start_i <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  // Stops sending and waits until every predicted flag has been checked.
  task automatic drain();
    start_i <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Writes all six planes in the given style, then the two indexes past the
  // last plane with random data, which the block must ignore. Only called
  // while the block is idle. Returns the coordinate spread that suits the
  // new planes.
  task automatic load_planes(input plane_style_e style, input int half, output int span);
    logic [63:0]  value;
    logic [15:0]  n [3];
    logic [15:0]  plane_dist;
    plane_style_e slot_style;
    int           pick;
    for (int i = 0; i < PLANE_REGS + 2; i++) begin
      n[0] = '0;
      n[1] = '0;
      n[2] = '0;
      plane_dist = '0;
      slot_style = style;
      if (style == STYLE_SPARSE) slot_style = $urandom_range(0, 1) ? STYLE_TILTED : STYLE_ZERO;
      case (slot_style)
        STYLE_CUBE: begin
          // Near and far bound z, right and left bound x, top and bottom
          // bound y; the first of each pair faces the positive direction.
          pick = (i / 2 == 0) ? 2 : (i / 2 == 1) ? 0 : 1;
          n[pick] = (i % 2 == 0) ? ONE_Q14 : -ONE_Q14;
          plane_dist = 16'(-half);
        end
        STYLE_TILTED: begin
          foreach (n[k]) n[k] = rand_s16(16384);
          plane_dist = 16'(-$urandom_range(1000, 30000));
        end
        STYLE_EXTREME: begin
          foreach (n[k]) begin
            pick = $urandom_range(0, 2);
            n[k] = (pick == 0) ? 16'h8000 : (pick == 1) ? 16'h7FFF : 16'h0000;
          end
          plane_dist = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
        end
        default: ;
      endcase
      value = {plane_dist, n[2], n[1], n[0]};
      if (slot_style == STYLE_RANDOM || i >= PLANE_REGS) value = {$urandom, $urandom};
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CFG_IDX_W'(i);
      cfg_wdata_i <= value;
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    span = 32767;
    if (style == STYLE_CUBE && 2 * half + 256 < 32767) span = 2 * half + 256;
  endtask

  initial begin
    query_t q;
    int     span;
    int     idle_pct;
    int     pick;
    int     dim;
    int     loads;

    board       = new();
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    query_word  = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    loads       = 0;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Right after reset every plane is all zero: the sum is exactly zero, so no point
    // or box is ever culled, however extreme the word; a negative-radius sphere is.
    send_query(make_query(OP_POINT, 32767, -32768, 32767, 0, '0, '0, '0, 0, 0, 0));
    send_query(make_query(OP_SPHERE, -32768, 32767, -32768, -32768, '0, '0, '0, 0, 0, 0));
    send_query(make_query(OP_BOX, 32767, 32767, 32767, 0, LANE_MAX, LANE_MIN,
                          48'hFFFF_FFFF_FFFF, 32767, -32768, -1));
    drain();

    // Axis-aligned cube of half-size 100.0 around the origin.
    load_planes(STYLE_CUBE, CUBE_HALF, span);
    loads++;
    // Points: center, exactly on a face (a zero sum stays inside), just past
    // it, and the field extremes.
    send_query(make_query(OP_POINT, 0, 0, 0, 0, '0, '0, '0, 0, 0, 0));
    send_query(make_query(OP_POINT, CUBE_HALF, 0, 0, 0, '0, '0, '0, 0, 0, 0));
    send_query(make_query(OP_POINT, CUBE_HALF + 1, 0, 0, 0, '0, '0, '0, 0, 0, 0));
    send_query(make_query(OP_POINT, 0, 0, -32768, 0, '0, '0, '0, 0, 0, 0));
    send_query(make_query(OP_POINT, 32767, 32767, 32767, 0, '0, '0, '0, 0, 0, 0));
    // Spheres: touching a face from outside stays inside, one unit less
    // radius culls, and a negative radius pushes the test outward.
    send_query(make_query(OP_SPHERE, CUBE_HALF + 100, 0, 0, 100, '0, '0, '0, 0, 0, 0));
    send_query(make_query(OP_SPHERE, CUBE_HALF + 100, 0, 0, 99, '0, '0, '0, 0, 0, 0));
    send_query(make_query(OP_SPHERE, 0, 0, 0, -32768, '0, '0, '0, 0, 0, 0));
    send_query(make_query(OP_SPHERE, 32767, 32767, 32767, 32767, '0, '0, '0, 0, 0, 0));
    // Boxes: exactly touching, one unit short, and the same with a negative
    // extent, which counts by magnitude only.
    send_query(make_query(OP_BOX, CUBE_HALF + 100, 0, 0, 0, AXIS_X, AXIS_Y, AXIS_Z,
                          100, 1, 1));
    send_query(make_query(OP_BOX, CUBE_HALF + 100, 0, 0, 0, AXIS_X, AXIS_Y, AXIS_Z,
                          99, 1, 1));
    send_query(make_query(OP_BOX, CUBE_HALF + 100, 0, 0, 0, AXIS_X, AXIS_Y, AXIS_Z,
                          -100, 1, 1));
    // Boxes at the lane and field extremes.
    send_query(make_query(OP_BOX, -32768, -32768, -32768, 0, LANE_MIN, LANE_MIN, LANE_MIN,
                          -32768, -32768, -32768));
    send_query(make_query(OP_BOX, 32767, -32768, 32767, 0, LANE_MAX, LANE_MAX, LANE_MAX,
                          32767, 32767, 32767));
    send_query(make_query(OP_BOX, -32768, 0, 0, -1, LANE_MIN, LANE_MAX, LANE_MIN,
                          32767, -32768, 0));
    // A box with no extent degenerates to its center point.
    send_query(make_query(OP_BOX, 0, 0, 0, 0, '0, '0, '0, 0, 0, 0));
    send_query(make_query(OP_BOX, 0, CUBE_HALF + 1, 0, 0, '0, '0, '0, 0, 0, 0));
    // The unused op code is never tested against any plane.
    send_query(make_query(OP_NONE, 32767, 32767, 32767, -32768, LANE_MAX, LANE_MIN,
                          LANE_MAX, -32768, -32768, -32768));

    // Random phases, each with its own plane setting. Idle bursts are absent,
    // sparse or dense by phase so that gaps land in every pipeline stage; the
    // last phase runs back to back throughout.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      load_planes(phase_style[ph], $urandom_range(16, 16000), span);
      loads++;
      idle_pct = (ph == RANDOM_PHASES - 1) ? 0 : (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 20 : 50;
      for (int w = 0; w < WORDS_PER_PHASE; w++) begin
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
          pause_sender($urandom_range(1, 9));
        pick = $urandom_range(0, 99);
        q.op = (pick < 30) ? OP_POINT : (pick < 60) ? OP_SPHERE : (pick < 95) ? OP_BOX : OP_NONE;
        q.center_x = coord(span);
        q.center_y = coord(span);
        q.center_z = coord(span);
        q.radius   = size_value(span);
        for (int k = 0; k < 3; k++) begin
          // Box axes: unit vectors along a random dimension with a random
          // sign half the time, otherwise tilted or fully random lanes.
          pick = $urandom_range(0, 3);
          dim  = $urandom_range(0, 2);
          if (pick == 0) begin
            q.axis[k] = 48'({$urandom, $urandom});
          end else if (pick == 1) begin
            q.axis[k] = {rand_s16(16384), rand_s16(16384), rand_s16(16384)};
          end else begin
            q.axis[k] = '0;
            q.axis[k][16*dim +: 16] = $urandom_range(0, 1) ? ONE_Q14 : -ONE_Q14;
          end
          q.extent[k] = size_value(span);
        end
        send_query(q);
      end
    end

    drain();
    board.report_leftover();
    $display("Checked %0d of %0d query words: %0d inside, %0d culled.",
             board.checked, board.accepted, board.inside_cnt, board.culled_cnt);
    $display("Planes were reloaded %0d times: zero, cube, tilted, random, extreme, sparse.",
             loads);
    if (board.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
